[hdl/mips_itype_execute_top_macros.svh]
// Assertion macros shared by the execute block RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MIPS_ITYPE_EXECUTE_TOP_MACROS_SVH
`define MIPS_ITYPE_EXECUTE_TOP_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define MIE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("property failed");

// Antecedent in one cycle implies consequent in the next.
`define MIE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

[hdl/mie_pkg.sv]
// Shared types, constants and helpers for the I-type execute block.
// No dependencies.
package mie_pkg;

  localparam int unsigned XLEN           = 32;
  localparam int unsigned REG_AW         = 5;
  localparam int unsigned REG_DEPTH      = 32;
  localparam int unsigned IMM_W          = 16;
  localparam int unsigned CMD_W          = 4;
  localparam int unsigned DMEM_WORDS_DEF = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_LUI   = 4'd0,
    CMD_ORI   = 4'd1,
    CMD_ANDI  = 4'd2,
    CMD_ADDIU = 4'd3,
    CMD_ADDI  = 4'd4,
    CMD_BNE   = 4'd5,
    CMD_BEQ   = 4'd6,
    CMD_LW    = 4'd7,
    CMD_SW    = 4'd8,
    CMD_LB    = 4'd9,
    CMD_SB    = 4'd10
  } cmd_e;

  typedef enum logic {
    DM_CLEAR,
    DM_RUN
  } dm_state_e;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  function automatic logic [XLEN-1:0] sext16(input logic [IMM_W-1:0] v);
    return {{(XLEN-IMM_W){v[IMM_W-1]}}, v};
  endfunction

  function automatic logic is_load(input cmd_e c);
    return (c == CMD_LW) || (c == CMD_LB);
  endfunction

endpackage

[hdl/mie_ifs.sv]
// Valid/ready channel interfaces for instruction input and result output.
// Depends on mie_pkg for field widths.
interface mie_in_if;
  logic                                valid;
  logic                                ready;
  logic [mie_pkg::CMD_W-1:0]           cmd;
  logic [mie_pkg::REG_AW-1:0]          src_index;
  logic [mie_pkg::REG_AW-1:0]          tgt_index;
  logic [mie_pkg::IMM_W-1:0]           immediate;

  modport source (output valid, cmd, src_index, tgt_index, immediate, input ready);
  modport sink   (input valid, cmd, src_index, tgt_index, immediate, output ready);
endinterface

interface mie_out_if;
  logic                                valid;
  logic                                ready;
  logic [mie_pkg::XLEN-1:0]            next_pc;
  logic                                branch_taken;
  logic                                reg_written;
  logic [mie_pkg::REG_AW-1:0]          dest_index;
  logic [mie_pkg::XLEN-1:0]            write_value;

  modport source (output valid, next_pc, branch_taken, reg_written, dest_index, write_value,
                  input ready);
  modport sink   (input valid, next_pc, branch_taken, reg_written, dest_index, write_value,
                  output ready);
endinterface

[hdl/mie_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mie_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/mie_regfile.sv]
// Register file: two read ports over two RAM copies, per-entry valid bits
// for the zero reset, bypass of the write landing on the read edge.
// Depends on mie_pkg and mie_ram.
module mie_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mie_pkg::rf_wr_t                wr_i,
  input  logic [mie_pkg::REG_AW-1:0]     raddr_a_i,
  input  logic [mie_pkg::REG_AW-1:0]     raddr_b_i,
  output logic [mie_pkg::XLEN-1:0]       rdata_a_o,
  output logic [mie_pkg::XLEN-1:0]       rdata_b_o
);

  logic [mie_pkg::REG_DEPTH-1:0] valid_q;
  logic [mie_pkg::REG_AW-1:0]    raddr_a_q, raddr_b_q;
  logic                          rvalid_a_q, rvalid_b_q;
  mie_pkg::rf_wr_t               last_q;
  logic [mie_pkg::XLEN-1:0]      ram_a, ram_b;

  mie_ram #(.WIDTH(mie_pkg::XLEN), .DEPTH(mie_pkg::REG_DEPTH)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (wr_i.en),
    .waddr_i(wr_i.idx),
    .wdata_i(wr_i.data),
    .raddr_i(raddr_a_i),
    .rdata_o(ram_a)
  );

  mie_ram #(.WIDTH(mie_pkg::XLEN), .DEPTH(mie_pkg::REG_DEPTH)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (wr_i.en),
    .waddr_i(wr_i.idx),
    .wdata_i(wr_i.data),
    .raddr_i(raddr_b_i),
    .rdata_o(ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      last_q     <= '0;
      raddr_a_q  <= '0;
      raddr_b_q  <= '0;
      rvalid_a_q <= 1'b0;
      rvalid_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
      last_q     <= wr_i;
      raddr_a_q  <= raddr_a_i;
      raddr_b_q  <= raddr_b_i;
      rvalid_a_q <= valid_q[raddr_a_i];
      rvalid_b_q <= valid_q[raddr_b_i];
    end
  end

  function automatic logic [mie_pkg::XLEN-1:0] pick(
    input logic [mie_pkg::REG_AW-1:0] idx,
    input logic                       rvalid,
    input logic [mie_pkg::XLEN-1:0]   ram,
    input mie_pkg::rf_wr_t            last
  );
    if (idx == '0) begin
      return '0;
    end else if (last.en && (last.idx == idx)) begin
      return last.data;
    end else if (rvalid) begin
      return ram;
    end
    return '0;
  endfunction

  assign rdata_a_o = pick(raddr_a_q, rvalid_a_q, ram_a, last_q);
  assign rdata_b_o = pick(raddr_b_q, rvalid_b_q, ram_b, last_q);

endmodule

[hdl/mie_dmem.sv]
// Data memory: word RAM with a zeroing sweep after reset and bypass of the
// write landing on the read edge.
// Depends on mie_pkg and mie_ram.
module mie_dmem #(
  parameter  int unsigned WORDS = mie_pkg::DMEM_WORDS_DEF,
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [AW-1:0]            raddr_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [mie_pkg::XLEN-1:0] wdata_i,
  output logic [mie_pkg::XLEN-1:0] rdata_o,
  output logic                     ready_o
);

  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  mie_pkg::dm_state_e       state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [mie_pkg::XLEN-1:0] ram_wdata, ram_rdata;
  logic                     lw_en_q;
  logic [AW-1:0]            lw_addr_q, raddr_q;
  logic [mie_pkg::XLEN-1:0] lw_data_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      mie_pkg::DM_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_WORD) begin
          state_d = mie_pkg::DM_RUN;
        end
      end
      mie_pkg::DM_RUN: ;
      default: state_d = mie_pkg::DM_CLEAR;
    endcase
  end

  always_comb begin
    ready_o   = 1'b0;
    ram_we    = we_i;
    ram_waddr = waddr_i;
    ram_wdata = wdata_i;
    unique case (state_q)
      mie_pkg::DM_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      mie_pkg::DM_RUN: ready_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mie_pkg::DM_CLEAR;
      clr_q     <= '0;
      lw_en_q   <= 1'b0;
      lw_addr_q <= '0;
      raddr_q   <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      lw_en_q   <= ram_we;
      lw_addr_q <= ram_waddr;
      raddr_q   <= raddr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_data_q <= ram_wdata;
  end

  mie_ram #(.WIDTH(mie_pkg::XLEN), .DEPTH(WORDS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  assign rdata_o = (lw_en_q && (lw_addr_q == raddr_q)) ? lw_data_q : ram_rdata;

endmodule

[hdl/mips_itype_execute_top.sv]
// Pipeline: operand stage, two word-slot reduction stages, memory stage and
// output register; one instruction per cycle while out_o.ready allows. An
// instruction that reads the destination of a load still in the two reduction
// stages waits until the load reaches the memory stage, whence it is bypassed.
// Reset: register file valid bits and pc clear at once; data memory is
// zeroed by a sweep over all DMEM_WORDS words with in_i.ready low.
module mips_itype_execute_top #(
  parameter int unsigned DMEM_WORDS = mie_pkg::DMEM_WORDS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mie_in_if.sink   in_i,
  mie_out_if.source out_o
);

  `include "mips_itype_execute_top_macros.svh"

  localparam int unsigned DM_AW  = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  localparam int unsigned WA_W   = 30;                 // word address bits
  localparam int unsigned SHIFT  = WA_W + DM_AW;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(DMEM_WORDS) - 64'd1) / 64'(DMEM_WORDS);
  localparam logic [WA_W:0]   RECIP   = RECIP64[WA_W:0];
  localparam logic [WA_W-1:0] WORDS_C = WA_W'(DMEM_WORDS);

  localparam int unsigned XL = mie_pkg::XLEN;
  localparam int unsigned RA = mie_pkg::REG_AW;

  typedef struct packed {
    mie_pkg::cmd_e  cmd;
    logic [RA-1:0]  rt;
    logic           wr;
    logic [XL-1:0]  val;
    logic [XL-1:0]  b;
    logic [1:0]     lane;
    logic [XL-1:0]  next_pc;
    logic           taken;
  } ctl_t;

  // stage 1: operands
  logic                      s1_v_q;
  mie_pkg::cmd_e             s1_cmd_q;
  logic [RA-1:0]             s1_rs_q, s1_rt_q;
  logic [mie_pkg::IMM_W-1:0] s1_imm_q;
  // stages 2..4
  logic          s2_v_q, s3_v_q, s4_v_q, out_v_q;
  ctl_t          s1_c, s2_q, s3_q, s4_q;
  logic [WA_W-1:0]  s1_x, s2_x_q, s3_x_q, s3_quo_q, s2_quo;
  logic [DM_AW-1:0] s3_slot, s4_slot_q;
  logic [2*WA_W:0]  s2_prod;

  logic [XL-1:0] pc_q;
  logic [XL-1:0] out_pc_q, out_val_q;
  logic          out_taken_q, out_wr_q;
  logic [RA-1:0] out_dest_q;

  logic out_free, s4_free, s3_free, s2_free, s1_free;
  logic s4_adv, s1_adv, hazard, in_acc;
  logic dm_ready;

  logic [XL-1:0] rf_a, rf_b, op_a, op_b, simm;
  logic [XL-1:0] dm_rdata, s4_fin, dm_wdata, s4_sh_mask;
  logic [4:0]    s4_sh;
  logic [7:0]    ld_byte;
  logic          dm_we;
  logic [RA-1:0] rf_ra, rf_rb;
  logic [DM_AW-1:0] dm_raddr;
  mie_pkg::rf_wr_t rf_wr;

  // handshake chain
  assign out_free = !out_v_q || out_o.ready;
  assign s4_free  = !s4_v_q || out_free;
  assign s4_adv   = s4_v_q && out_free;
  assign s3_free  = !s3_v_q || s4_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_adv   = s1_v_q && s2_free && !hazard;
  assign s1_free  = !s1_v_q || s1_adv;
  assign in_i.ready = s1_free && dm_ready;
  assign in_acc   = in_i.valid && in_i.ready;

  // pending-write bypass for an operand; loads in stages 2/3 stall instead
  function automatic logic [XL-1:0] fwd(
    input logic [RA-1:0] idx, input logic [XL-1:0] rf_val,
    input logic v2, input ctl_t c2, input logic v3, input ctl_t c3,
    input logic v4, input ctl_t c4, input logic [XL-1:0] fin4
  );
    if (v2 && c2.wr && (c2.rt == idx)) begin
      return c2.val;
    end else if (v3 && c3.wr && (c3.rt == idx)) begin
      return c3.val;
    end else if (v4 && c4.wr && (c4.rt == idx)) begin
      return fin4;
    end
    return rf_val;
  endfunction

  function automatic logic load_hit(
    input logic v, input ctl_t c, input logic [RA-1:0] rs, input logic [RA-1:0] rt
  );
    return v && c.wr && mie_pkg::is_load(c.cmd) && ((c.rt == rs) || (c.rt == rt));
  endfunction

  assign hazard = load_hit(s2_v_q, s2_q, s1_rs_q, s1_rt_q) ||
                  load_hit(s3_v_q, s3_q, s1_rs_q, s1_rt_q);

  assign rf_ra = s1_free ? in_i.src_index : s1_rs_q;
  assign rf_rb = s1_free ? in_i.tgt_index : s1_rt_q;

  mie_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (rf_wr),
    .raddr_a_i(rf_ra),
    .raddr_b_i(rf_rb),
    .rdata_a_o(rf_a),
    .rdata_b_o(rf_b)
  );

  // stage 1 execute
  always_comb begin
    logic wr;
    logic taken;
    logic [XL-1:0] val;
    logic [XL-1:0] addr;
    simm  = mie_pkg::sext16(s1_imm_q);
    op_a  = fwd(s1_rs_q, rf_a, s2_v_q, s2_q, s3_v_q, s3_q, s4_v_q, s4_q, s4_fin);
    op_b  = fwd(s1_rt_q, rf_b, s2_v_q, s2_q, s3_v_q, s3_q, s4_v_q, s4_q, s4_fin);
    wr    = 1'b0;
    taken = 1'b0;
    val   = '0;
    unique case (s1_cmd_q) inside
      mie_pkg::CMD_LUI: begin
        val = {s1_imm_q, 16'h0000};
        wr  = 1'b1;
      end
      mie_pkg::CMD_ORI: begin
        val = op_a | {16'h0000, s1_imm_q};
        wr  = 1'b1;
      end
      mie_pkg::CMD_ANDI: begin
        val = op_a & {16'h0000, s1_imm_q};
        wr  = 1'b1;
      end
      mie_pkg::CMD_ADDIU, mie_pkg::CMD_ADDI: begin
        val = op_a + simm;
        wr  = 1'b1;
      end
      mie_pkg::CMD_BNE: taken = (op_a != op_b);
      mie_pkg::CMD_BEQ: taken = (op_a == op_b);
      mie_pkg::CMD_LW, mie_pkg::CMD_LB: wr = 1'b1;
      default: ;
    endcase
    addr = op_a + simm;
    s1_x = addr[XL-1:2];
    s1_c.cmd     = s1_cmd_q;
    s1_c.rt      = s1_rt_q;
    s1_c.wr      = wr && (s1_rt_q != '0);
    s1_c.val     = val;
    s1_c.b       = op_b;
    s1_c.lane    = addr[1:0];
    s1_c.taken   = taken;
    s1_c.next_pc = pc_q + 32'd4 + (taken ? {simm[XL-3:0], 2'b00} : '0);
  end

  // word slot = word address mod DMEM_WORDS, by reciprocal over two stages
  assign s2_prod = s2_x_q * RECIP;
  assign s2_quo  = WA_W'(s2_prod >> SHIFT);
  assign s3_slot = DM_AW'(s3_x_q - WA_W'(s3_quo_q * WORDS_C));

  assign dm_raddr = s4_free ? s3_slot : s4_slot_q;

  mie_dmem #(.WORDS(DMEM_WORDS)) u_dmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .raddr_i(dm_raddr),
    .we_i   (dm_we),
    .waddr_i(s4_slot_q),
    .wdata_i(dm_wdata),
    .rdata_o(dm_rdata),
    .ready_o(dm_ready)
  );

  // stage 4 memory access and writeback
  always_comb begin
    s4_sh      = {s4_q.lane, 3'b000};
    ld_byte    = dm_rdata[s4_sh +: 8];
    s4_sh_mask = 32'h0000_00ff << s4_sh;
    s4_fin     = s4_q.val;
    dm_wdata   = s4_q.b;
    dm_we      = 1'b0;
    case (s4_q.cmd)
      mie_pkg::CMD_LW: s4_fin = dm_rdata;
      mie_pkg::CMD_LB: s4_fin = {{24{ld_byte[7]}}, ld_byte};
      mie_pkg::CMD_SW: dm_we = s4_adv;
      mie_pkg::CMD_SB: begin
        dm_we    = s4_adv;
        dm_wdata = (dm_rdata & ~s4_sh_mask) | ({24'h000000, s4_q.b[7:0]} << s4_sh);
      end
      default: ;
    endcase
    rf_wr.en   = s4_adv && s4_q.wr;
    rf_wr.idx  = s4_q.rt;
    rf_wr.data = s4_fin;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      pc_q    <= '0;
    end else begin
      if (s1_free) s1_v_q <= in_acc;
      if (s2_free) s2_v_q <= s1_adv;
      if (s3_free) s3_v_q <= s2_v_q;
      if (s4_free) s4_v_q <= s3_v_q;
      if (out_free) out_v_q <= s4_v_q;
      if (s1_adv) pc_q <= s1_c.next_pc;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q <= mie_pkg::cmd_e'(in_i.cmd);
      s1_rs_q  <= in_i.src_index;
      s1_rt_q  <= in_i.tgt_index;
      s1_imm_q <= in_i.immediate;
    end
    if (s2_free && s1_adv) begin
      s2_q   <= s1_c;
      s2_x_q <= s1_x;
    end
    if (s3_free) begin
      s3_q     <= s2_q;
      s3_x_q   <= s2_x_q;
      s3_quo_q <= s2_quo;
    end
    if (s4_free) begin
      s4_q      <= s3_q;
      s4_slot_q <= s3_slot;
    end
    if (s4_adv) begin
      out_pc_q    <= s4_q.next_pc;
      out_taken_q <= s4_q.taken;
      out_wr_q    <= s4_q.wr;
      out_dest_q  <= s4_q.wr ? s4_q.rt : '0;
      out_val_q   <= s4_q.wr ? s4_fin : '0;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.next_pc      = out_pc_q;
  assign out_o.branch_taken = out_taken_q;
  assign out_o.reg_written  = out_wr_q;
  assign out_o.dest_index   = out_dest_q;
  assign out_o.write_value  = out_val_q;

  `MIE_ASSERT(a_no_accept_in_clear, clk_i, rst_ni, !dm_ready |-> !in_i.ready)
  `MIE_ASSERT_NEXT(a_mem_stage_to_out, clk_i, rst_ni, s4_adv, out_v_q)
  `MIE_ASSERT_NEXT(a_pc_step, clk_i, rst_ni, s1_adv && !s1_c.taken, pc_q == ($past(pc_q) + 32'd4))
  `MIE_ASSERT(a_slot_in_range, clk_i, rst_ni, s4_v_q |-> (s4_slot_q <= DM_AW'(DMEM_WORDS - 1)))

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for mips_itype_execute_top: queued instruction driver,
// result monitor and an in-bench executor that tracks registers, pc and memory.
// Depends on mie_pkg, the mie_in_if/mie_out_if interfaces and the RTL top.
module tb_top;

  localparam int unsigned XLEN      = mie_pkg::XLEN;
  localparam int unsigned REG_AW    = mie_pkg::REG_AW;
  localparam int unsigned REG_DEPTH = mie_pkg::REG_DEPTH;
  localparam int unsigned IMM_W     = mie_pkg::IMM_W;
  localparam int unsigned CMD_W     = mie_pkg::CMD_W;

  localparam int unsigned DMEM_WORDS = mie_pkg::DMEM_WORDS_DEF;
  // nothing accepted for this long means the block is stuck; covers the clear sweep
  localparam int unsigned STALL_LIMIT = 4 * DMEM_WORDS + 1000;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(mie_pkg::CMD_SB + 1);
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic [IMM_W-1:0]  imm;
    int unsigned       gap;    // idle cycles before this transaction
    bit                drain;  // hold until every outstanding result is back
  } instr_t;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              taken;
    logic              wr;
    logic [REG_AW-1:0] dest;
    logic [XLEN-1:0]   value;
  } exec_result_t;

  logic clk;
  logic rst_n;

  mie_in_if  in_if ();
  mie_out_if out_if ();

  mips_itype_execute_top #(
    .DMEM_WORDS(DMEM_WORDS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // architectural state as the bench sees it
  logic [XLEN-1:0] gpr [REG_DEPTH];
  logic [XLEN-1:0] arch_pc;
  logic [XLEN-1:0] dmem [DMEM_WORDS];

  instr_t       instr_q [$];
  exec_result_t result_q [$];

  int unsigned in_issued;
  int unsigned in_taken;
  int unsigned out_taken;
  int unsigned out_seen;
  int unsigned hold_cnt;
  int unsigned rdy_wait;
  int unsigned idle_cycles;
  int unsigned err_cnt;
  int unsigned gen_cnt;
  bit          calm_in;
  bit          calm_out;
  bit          drain_next;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic exec_result_t run_itype(instr_t ins);
    exec_result_t    res;
    logic [XLEN-1:0] simm;
    logic [XLEN-1:0] opa;
    logic [XLEN-1:0] opb;
    logic [XLEN-1:0] addr;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] npc;
    int unsigned     slot;
    int unsigned     lane;
    logic            wr;
    logic            taken;
    simm  = {{(XLEN-IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
    opa   = (ins.rs == 0) ? '0 : gpr[ins.rs];
    opb   = (ins.rt == 0) ? '0 : gpr[ins.rt];
    addr  = opa + simm;
    slot  = (addr >> 2) % DMEM_WORDS;
    lane  = int'(addr[1:0]) * 8;
    val   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    case (ins.cmd)
      mie_pkg::CMD_LUI: begin
        val = {ins.imm, 16'h0000};
        wr  = 1'b1;
      end
      mie_pkg::CMD_ORI: begin
        val = opa | {16'h0000, ins.imm};
        wr  = 1'b1;
      end
      mie_pkg::CMD_ANDI: begin
        val = opa & {16'h0000, ins.imm};
        wr  = 1'b1;
      end
      mie_pkg::CMD_ADDIU, mie_pkg::CMD_ADDI: begin
        val = opa + simm;
        wr  = 1'b1;
      end
      mie_pkg::CMD_BNE: taken = (opa != opb);
      mie_pkg::CMD_BEQ: taken = (opa == opb);
      mie_pkg::CMD_LW: begin
        val = dmem[slot];
        wr  = 1'b1;
      end
      mie_pkg::CMD_SW: dmem[slot] = opb;
      mie_pkg::CMD_LB: begin
        val = {{24{dmem[slot][lane+7]}}, dmem[slot][lane +: 8]};
        wr  = 1'b1;
      end
      mie_pkg::CMD_SB: dmem[slot][lane +: 8] = opb[7:0];
      default: ;
    endcase
    npc = arch_pc + 32'd4;
    if (taken) npc = npc + (simm << 2);
    if (ins.rt == 0) wr = 1'b0;
    if (wr) gpr[ins.rt] = val;
    arch_pc     = npc;
    res.next_pc = npc;
    res.taken   = taken;
    res.wr      = wr;
    res.dest    = wr ? ins.rt : '0;
    res.value   = wr ? val : '0;
    return res;
  endfunction

  task automatic check_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // input and output monitors share one block so a prediction always lands first
  always @(posedge clk) begin
    instr_t       ins;
    exec_result_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_if.valid && in_if.ready) begin
        ins.cmd   = in_if.cmd;
        ins.rs    = in_if.src_index;
        ins.rt    = in_if.tgt_index;
        ins.imm   = in_if.immediate;
        ins.gap   = 0;
        ins.drain = 1'b0;
        result_q.push_back(run_itype(ins));
        in_taken++;
        idle_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        idle_cycles = 0;
        out_taken++;
        if (result_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual next_pc %h value %h",
                   $time, out_if.next_pc, out_if.write_value);
        end else begin
          want = result_q.pop_front();
          check_field("next_pc", want.next_pc, out_if.next_pc);
          check_field("branch_taken", XLEN'(want.taken), XLEN'(out_if.branch_taken));
          check_field("reg_written", XLEN'(want.wr), XLEN'(out_if.reg_written));
          check_field("dest_index", XLEN'(want.dest), XLEN'(out_if.dest_index));
          check_field("write_value", want.value, out_if.write_value);
        end
      end
    end
  end

  // instruction driver: one transaction on the bus until it is taken
  always @(negedge clk) begin
    instr_t cur;
    if (rst_n && in_issued == in_taken) begin
      if (instr_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (hold_cnt < instr_q[0].gap) begin
        hold_cnt++;
        in_if.valid <= 1'b0;
      end else if (instr_q[0].drain && result_q.size() != 0) begin
        in_if.valid <= 1'b0;
      end else begin
        cur = instr_q.pop_front();
        in_if.cmd       <= cur.cmd;
        in_if.src_index <= cur.rs;
        in_if.tgt_index <= cur.rt;
        in_if.immediate <= cur.imm;
        in_if.valid     <= 1'b1;
        in_issued++;
        hold_cnt = 0;
      end
    end
  end

  // result receiver: a fresh stall drawn after every transaction
  always @(negedge clk) begin
    if (out_taken != out_seen) begin
      out_seen = out_taken;
      if (out_seen % 97 == 0) calm_out = ($urandom_range(0, 3) == 0);
      rdy_wait = calm_out ? 0 : $urandom_range(0, 5);
    end
    if (rdy_wait != 0) begin
      rdy_wait--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_item(logic [CMD_W-1:0] c, logic [REG_AW-1:0] s, logic [REG_AW-1:0] t,
                           logic [IMM_W-1:0] i);
    instr_t ins;
    ins.cmd    = c;
    ins.rs     = s;
    ins.rt     = t;
    ins.imm    = i;
    ins.gap    = calm_in ? 0 : $urandom_range(0, 5);
    ins.drain  = drain_next;
    drain_next = 1'b0;
    instr_q.push_back(ins);
    gen_cnt++;
  endtask

  // mostly a small pool so that dependencies between neighbours are common
  function automatic logic [REG_AW-1:0] pick_reg();
    return REG_AW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, 7));
  endfunction

  function automatic logic [IMM_W-1:0] mem_offset();
    return IMM_W'(($urandom_range(0, 4) < 3) ? $urandom_range(0, 63)
                                              : $urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [IMM_W-1:0] any_imm();
    return IMM_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [CMD_W-1:0] alu_cmd();
    return CMD_W'($urandom_range(mie_pkg::CMD_LUI, mie_pkg::CMD_ADDI));
  endfunction

  function automatic logic [CMD_W-1:0] branch_cmd();
    return CMD_W'($urandom_range(mie_pkg::CMD_BNE, mie_pkg::CMD_BEQ));
  endfunction

  function automatic logic [REG_AW-1:0] any_reg();
    return REG_AW'($urandom_range(0, 31));
  endfunction

  initial begin
    logic [REG_AW-1:0] base;
    logic [REG_AW-1:0] reg_a;
    logic [REG_AW-1:0] reg_b;
    logic [IMM_W-1:0]  offs;
    int unsigned       fill;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd       = '0;
    in_if.src_index = '0;
    in_if.tgt_index = '0;
    in_if.immediate = '0;
    out_if.ready    = 1'b0;
    for (int k = 0; k < REG_DEPTH; k++) gpr[k] = '0;
    for (int k = 0; k < DMEM_WORDS; k++) dmem[k] = '0;
    arch_pc = '0;

    // directed: field extremes, every command, dest zero, wraps and misalignment
    push_item(mie_pkg::CMD_LUI,   5'd0,  5'd1,  16'hFFFF);
    push_item(mie_pkg::CMD_LUI,   5'd0,  5'd0,  16'h1234);
    push_item(mie_pkg::CMD_ORI,   5'd1,  5'd1,  16'hFFFF);
    push_item(mie_pkg::CMD_ANDI,  5'd1,  5'd2,  16'h8001);
    push_item(mie_pkg::CMD_ADDIU, 5'd0,  5'd3,  16'h8000);
    push_item(mie_pkg::CMD_ADDI,  5'd1,  5'd4,  16'h0001);
    push_item(mie_pkg::CMD_ADDIU, 5'd1,  5'd31, 16'h7FFF);
    push_item(mie_pkg::CMD_SW,    5'd0,  5'd1,  16'h0000);
    push_item(mie_pkg::CMD_SW,    5'd0,  5'd3,  16'hFFFC);
    push_item(mie_pkg::CMD_LW,    5'd0,  5'd5,  16'hFFFC);
    push_item(mie_pkg::CMD_LW,    5'd0,  5'd6,  16'h0003);
    push_item(mie_pkg::CMD_SB,    5'd0,  5'd2,  16'h0005);
    push_item(mie_pkg::CMD_LB,    5'd0,  5'd7,  16'h0005);
    push_item(mie_pkg::CMD_LB,    5'd0,  5'd8,  16'h0003);
    push_item(mie_pkg::CMD_ADDIU, 5'd8,  5'd9,  16'h0001);
    push_item(mie_pkg::CMD_LW,    5'd0,  5'd0,  16'h0000);
    push_item(mie_pkg::CMD_SW,    5'd1,  5'd31, 16'h1001);
    push_item(mie_pkg::CMD_LW,    5'd1,  5'd10, 16'h1001);
    push_item(mie_pkg::CMD_BEQ,   5'd0,  5'd0,  16'hFFFF);
    push_item(mie_pkg::CMD_BNE,   5'd1,  5'd0,  16'h7FFF);
    push_item(mie_pkg::CMD_BEQ,   5'd1,  5'd0,  16'h0010);
    push_item(mie_pkg::CMD_BNE,   5'd0,  5'd0,  16'h0010);
    push_item(mie_pkg::CMD_BEQ,   5'd31, 5'd31, 16'h8000);
    push_item(CMD_FIRST_UNUSED,   5'd31, 5'd31, 16'hFFFF);
    push_item(CMD_LAST_CODE,      5'd5,  5'd1,  16'h0000);

    drain_next = 1'b1;
    fill = gen_cnt + RANDOM_ITEMS;
    while (gen_cnt < fill) begin
      if ($urandom_range(0, 11) == 0) calm_in = ~calm_in;
      if ($urandom_range(0, 299) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: push_item(alu_cmd(), pick_reg(), pick_reg(), any_imm());
        3, 4: begin
          // store, a little other work, then a load with the same base register and offset
          base = pick_reg();
          offs = mem_offset();
          push_item($urandom_range(0, 1) ? mie_pkg::CMD_SW : mie_pkg::CMD_SB, base,
                    pick_reg(), offs);
          repeat ($urandom_range(0, 2)) push_item(alu_cmd(), pick_reg(), pick_reg(), any_imm());
          push_item($urandom_range(0, 1) ? mie_pkg::CMD_LW : mie_pkg::CMD_LB, base,
                    pick_reg(), offs);
        end
        5: begin
          // load followed at once by a consumer of the loaded register
          reg_a = REG_AW'($urandom_range(1, 7));
          push_item($urandom_range(0, 1) ? mie_pkg::CMD_LW : mie_pkg::CMD_LB, pick_reg(),
                    reg_a, mem_offset());
          case ($urandom_range(0, 3))
            0: push_item(alu_cmd(), reg_a, pick_reg(), any_imm());
            1: push_item(branch_cmd(), reg_a, pick_reg(), any_imm());
            2: push_item($urandom_range(0, 1) ? mie_pkg::CMD_SW : mie_pkg::CMD_SB,
                         pick_reg(), reg_a, mem_offset());
            default: push_item(CMD_W'($urandom_range(mie_pkg::CMD_LW, mie_pkg::CMD_SB)),
                               reg_a, pick_reg(), mem_offset());
          endcase
        end
        6: push_item(branch_cmd(), pick_reg(), pick_reg(), any_imm());
        7: begin
          // full 32-bit constant, then a comparison against it
          reg_b = REG_AW'($urandom_range(1, 7));
          push_item(mie_pkg::CMD_LUI, pick_reg(), reg_b, any_imm());
          push_item(mie_pkg::CMD_ORI, reg_b, reg_b, any_imm());
          push_item(branch_cmd(), reg_b, pick_reg(), any_imm());
        end
        8: begin
          if ($urandom_range(0, 1))
            push_item(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE)), any_reg(),
                      any_reg(), any_imm());
          else
            push_item(CMD_W'($urandom_range(0, CMD_LAST_CODE)), any_reg(),
                      any_reg(), any_imm());
        end
        default: begin
          // chain of ALU ops each feeding the next
          reg_a = pick_reg();
          repeat ($urandom_range(2, 4)) begin
            reg_b = pick_reg();
            push_item(alu_cmd(), reg_a, reg_b, any_imm());
            reg_a = reg_b;
          end
        end
      endcase
    end

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    while (instr_q.size() != 0 || in_issued != in_taken || result_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
